FILE: rtl/core/bbf_pkg.sv
// ----------------------------------------------------------------------------
// bbf_pkg
// Shared widths and codes of the buddy bitmap free block.
// ----------------------------------------------------------------------------
package bbf_pkg;

   // fixed field widths of the channels
   localparam int NODE_W = 10;
   localparam int CNT_W  = 4;

   // action codes
   localparam logic ACT_FREE = 1'b0;
   localparam logic ACT_SET  = 1'b1;

   // widest bitmap row, as log2 of bits per row
   localparam int MAX_COL_AW = 5;

endpackage

FILE: rtl/core/bbf_if.sv
// ----------------------------------------------------------------------------
// bbf_req_if / bbf_rsp_if
// Valid/ready channels of the buddy bitmap free block.
// ----------------------------------------------------------------------------
interface bbf_req_if import bbf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              action;
   logic [NODE_W-1:0] node_index;
   logic              bit_value;

   modport source (output valid, action, node_index, bit_value, input ready);
   modport sink   (input valid, action, node_index, bit_value, output ready);
endinterface

interface bbf_rsp_if import bbf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              error;
   logic [NODE_W-1:0] top_freed_index;
   logic [CNT_W-1:0]  merge_count;

   modport source (output valid, error, top_freed_index, merge_count, input ready);
   modport sink   (input valid, error, top_freed_index, merge_count, output ready);
endinterface

FILE: rtl/core/bbf_map_ram.sv
// ----------------------------------------------------------------------------
// bbf_map_ram
// Row-organized bitmap memory, one write port with per-bit mask, one
// registered read port.
// ----------------------------------------------------------------------------
module bbf_map_ram #(
   parameter int ROW_AW = 5,
   parameter int COL_AW = 5
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [ROW_AW-1:0]      wr_row,
   input  logic [(1<<COL_AW)-1:0] wr_mask,
   input  logic                   wr_bit,
   input  logic                   rd_en,
   input  logic [ROW_AW-1:0]      rd_row,
   output logic [(1<<COL_AW)-1:0] rd_data
);

   localparam int ROW_W = 1 << COL_AW;
   localparam int ROWS  = 1 << ROW_AW;

   logic [ROW_W-1:0] map_ff [ROWS];
   logic [ROW_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         for (int b = 0; b < ROW_W; b++) begin
            if (wr_mask[b]) begin
               map_ff[wr_row][b] <= wr_bit;
            end
         end
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= map_ff[rd_row];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/buddy_bitmap_free_core.sv
// ----------------------------------------------------------------------------
// buddy_bitmap_free_core
// Used/free bitmap of a heap-ordered buddy tree: frees a node with its
// subtree and coalesces upward, or writes a single bit.
// ----------------------------------------------------------------------------
//
//   channel  dir  transfer when          payload
//   -------  ---  ---------------------  -------------------------------------
//   req_if   in   valid & ready          action, node_index, bit_value
//   rsp_if   out  valid & ready          error, top_freed_index, merge_count
//
// Sequence: set_bit and a bad index go straight to the result; free sweeps
//   the rows of the subtree clear one row a cycle (36 rows for the root),
//   then merges upward. The single write port of the RAM sets this rate.
// Reset: synchronous, then a clearing pass of one write per row (32 rows by
//   default) with req ready low.
// Stalls: one item at a time; a waiting result holds only the next finish.
//
module buddy_bitmap_free_core import bbf_pkg::*; #(
   parameter int TREE_LEVELS = 9
) (
   input  logic       clock,
   input  logic       reset,
   bbf_req_if.sink    req_if,
   bbf_rsp_if.source  rsp_if
);

   // address of one map entry, and its split into row and column
   localparam int          AW       = TREE_LEVELS + 1;
   localparam int unsigned MAP_BITS = 1 << AW;
   localparam int          RB       = (AW - 1 < MAX_COL_AW) ? (AW - 1) : MAX_COL_AW;
   localparam int          RIW      = AW - RB;
   localparam int          ROW_W    = 1 << RB;

   // sequencer states
   localparam logic [2:0] ST_INIT = 3'd0;
   localparam logic [2:0] ST_IDLE = 3'd1;
   localparam logic [2:0] ST_CLR  = 3'd2;
   localparam logic [2:0] ST_DEC  = 3'd3;
   localparam logic [2:0] ST_WALK = 3'd4;
   localparam logic [2:0] ST_CHK  = 3'd5;
   localparam logic [2:0] ST_FIN  = 3'd6;

   logic [2:0]        state_ff, state_in;
   logic [RIW-1:0]    row_ff, row_in;       // clear sweep / init row
   logic [AW-1:0]     lo_ff, lo_in;         // first entry of current level
   logic [AW-1:0]     hi_ff, hi_in;         // last entry of current level
   logic [AW-1:0]     node_ff, node_in;
   logic [AW-1:0]     p_ff, p_in;           // parent being merged
   logic              err_ff, err_in;
   logic [NODE_W-1:0] top_ff, top_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_err_ff;
   logic [NODE_W-1:0] rsp_top_ff;
   logic [CNT_W-1:0]  rsp_cnt_ff;
   logic              rsp_load;

   // RAM ports
   logic              wr_en;
   logic [RIW-1:0]    wr_row;
   logic [ROW_W-1:0]  wr_mask;
   logic              wr_bit;
   logic              rd_en;
   logic [RIW-1:0]    rd_row;
   logic [ROW_W-1:0]  rd_data;

   logic              req_xfer;
   logic [AW-1:0]     req_addr;
   logic [AW-1:0]     req_bud;
   logic              req_bad;
   logic [AW-1:0]     node_bud;
   logic [AW-1:0]     p_bud;
   logic [AW:0]       lo_next;
   logic [AW-1:0]     hi_next;
   logic [RB-1:0]     lo_col;
   logic [RB-1:0]     hi_col;
   logic [ROW_W-1:0]  clr_mask;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_xfer     = req_if.valid && req_if.ready;
   assign req_addr     = AW'(req_if.node_index);
   assign req_bud      = req_addr ^ AW'(1);
   // entry 0 is no node; indexes past the map are rejected too
   assign req_bad      = (req_if.node_index == '0) ||
                         (32'(req_if.node_index) >= MAP_BITS);
   assign node_bud     = node_ff ^ AW'(1);
   assign p_bud        = p_ff ^ AW'(1);

   // next level of the subtree: children span [2*lo, 2*hi+1]
   assign lo_next = {lo_ff, 1'b0};
   assign hi_next = {hi_ff[AW-2:0], 1'b1};

   // column range of the current level within the row being swept
   always_comb begin
      lo_col = (row_ff == lo_ff[AW-1:RB]) ? lo_ff[RB-1:0] : '0;
      hi_col = (row_ff == hi_ff[AW-1:RB]) ? hi_ff[RB-1:0] : '1;
      for (int b = 0; b < ROW_W; b++) begin
         clr_mask[b] = (RB'(b) >= lo_col) && (RB'(b) <= hi_col);
      end
   end

   // RAM access per state
   always_comb begin
      wr_en   = 1'b0;
      wr_row  = '0;
      wr_mask = '0;
      wr_bit  = 1'b0;
      rd_en   = 1'b0;
      rd_row  = '0;
      unique case (state_ff)
         ST_INIT: begin
            wr_en   = 1'b1;
            wr_row  = row_ff;
            wr_mask = '1;
         end
         ST_IDLE: begin
            if (req_xfer && !req_bad) begin
               if (req_if.action == ACT_SET) begin
                  wr_en   = 1'b1;
                  wr_row  = req_addr[AW-1:RB];
                  wr_mask = ROW_W'(1) << req_addr[RB-1:0];
                  wr_bit  = req_if.bit_value;
               end else begin
                  // buddy lies outside the subtree: fetch it now
                  rd_en  = 1'b1;
                  rd_row = req_bud[AW-1:RB];
               end
            end
         end
         ST_CLR: begin
            wr_en   = 1'b1;
            wr_row  = row_ff;
            wr_mask = clr_mask;
         end
         ST_WALK: begin
            wr_en   = 1'b1;
            wr_row  = p_ff[AW-1:RB];
            wr_mask = ROW_W'(1) << p_ff[RB-1:0];
            rd_en   = 1'b1;
            rd_row  = p_bud[AW-1:RB];
         end
         default: begin
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      node_in      = node_ff;
      p_in         = p_ff;
      err_in       = err_ff;
      top_in       = top_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_load     = 1'b0;
      unique case (state_ff)
         ST_INIT: begin
            row_in = row_ff + RIW'(1);
            if (&row_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_xfer) begin
               node_in = req_addr;
               lo_in   = req_addr;
               hi_in   = req_addr;
               row_in  = req_addr[AW-1:RB];
               err_in  = req_bad;
               top_in  = req_bad ? '0 : req_if.node_index;
               cnt_in  = '0;
               if (req_bad || req_if.action == ACT_SET) begin
                  state_in = ST_FIN;
               end else begin
                  state_in = ST_CLR;
               end
            end
         end
         ST_CLR: begin
            if (row_ff == hi_ff[AW-1:RB]) begin
               lo_in = lo_next[AW-1:0];
               hi_in = hi_next;
               if (lo_next[AW]) begin
                  state_in = ST_DEC;
               end else begin
                  row_in = lo_next[AW-1:RB];
               end
            end else begin
               row_in = row_ff + RIW'(1);
            end
         end
         ST_DEC: begin
            // root has no parent; a used buddy stops the merge
            p_in = node_ff >> 1;
            if (!rd_data[node_bud[RB-1:0]] && node_ff != AW'(1)) begin
               state_in = ST_WALK;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_WALK: begin
            top_in   = NODE_W'(p_ff);
            cnt_in   = cnt_ff + CNT_W'(1);
            state_in = ST_CHK;
         end
         ST_CHK: begin
            if (rd_data[p_bud[RB-1:0]] || p_ff == AW'(1)) begin
               state_in = ST_FIN;
            end else begin
               p_in     = p_ff >> 1;
               state_in = ST_WALK;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      node_ff <= node_in;
      p_ff    <= p_in;
      err_ff  <= err_in;
      top_ff  <= top_in;
      cnt_ff  <= cnt_in;
      if (rsp_load) begin
         rsp_err_ff <= err_ff;
         rsp_top_ff <= top_ff;
         rsp_cnt_ff <= cnt_ff;
      end
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.error           = rsp_err_ff;
   assign rsp_if.top_freed_index = rsp_top_ff;
   assign rsp_if.merge_count     = rsp_cnt_ff;

   bbf_map_ram #(
      .ROW_AW (RIW),
      .COL_AW (RB)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_row  (wr_row),
      .wr_mask (wr_mask),
      .wr_bit  (wr_bit),
      .rd_en   (rd_en),
      .rd_row  (rd_row),
      .rd_data (rd_data)
   );

endmodule
